>>> src/crd_pkg.sv
// Shared types and constants for the camera response deframer.
package crd_pkg;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_Y    = 8'h59;
    localparam logic [7:0] CMD_FW  = 8'h5A;
    localparam logic [7:0] CMD_MDL = 8'h57;
    localparam logic [7:0] CH_LOW  = 8'd32;
    localparam logic [7:0] CH_HIGH = 8'd126;
    localparam logic [5:0] MAX_TEXT = 6'd55;
    localparam logic [15:0] TIMEOUT_RESET = 16'd600;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_REQ  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_LEN      = 3'd3;
    localparam logic [2:0] ST_FTIMEOUT = 3'd4;
    localparam logic [2:0] ST_RTIMEOUT = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    localparam logic [1:0] ID_NONE = 2'd0;
    localparam logic [1:0] ID_FW   = 2'd1;
    localparam logic [1:0] ID_MDL  = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [7:0]  op_code;
        logic [7:0]  command;
        logic        has_ack;
        logic [15:0] payload_length;
        logic [5:0]  text_length;
        logic [1:0]  identity;
        logic [7:0]  text_char;
        logic        request_ok;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       store_byte;  // write byte at count, bump count
        logic       clr_count;
        logic       rd_en;       // issue RAM read at rd_addr
        logic       ld_byte;     // latch read data into target
        logic [2:0] ld_sel;
        logic       text_start;
        logic       text_step;   // consume one read payload byte
    } t_cmd;

    localparam logic [2:0] LD_OP   = 3'd0;
    localparam logic [2:0] LD_CMD  = 3'd1;
    localparam logic [2:0] LD_ACK  = 3'd2;
    localparam logic [2:0] LD_LENL = 3'd3;
    localparam logic [2:0] LD_LENH = 3'd4;

endpackage

>>> src/crd_if.sv
// Valid/ready stream interface carrying one payload beat.
interface crd_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/crd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module crd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> src/crd_ctrl.sv
// Controller: sequences byte intake, end detection, frame decode and text emission.
module crd_ctrl #(
    parameter int FRAME_DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    crd_if.sink                     i_in,
    crd_if.source                   o_out,
    input  logic [15:0]             i_timeout,
    input  logic [$clog2(FRAME_DEPTH+1)-1:0] i_count,
    input  logic                    i_end_seen,
    input  logic [7:0]              i_op,
    input  logic [7:0]              i_cmd,
    input  logic                    i_ack,
    input  logic [15:0]             i_len,
    input  logic [5:0]              i_tl,
    input  logic                    i_text_ok,
    input  logic [7:0]              i_text_char,
    input  logic                    i_text_is_zero,
    output crd_pkg::t_cmd           o_cmd,
    output logic [$clog2(FRAME_DEPTH)-1:0] o_rd_addr
);
    import crd_pkg::*;

    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_HDR    = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_EMIT   = 4'd6;
    localparam logic [3:0] S_EMRD   = 4'd7;
    localparam logic [3:0] S_EMCH   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_idle, n_idle, r_req, n_req;
    logic        r_await, n_await, r_ok, n_ok;
    logic [2:0]  r_hidx, n_hidx;     // header read index
    logic [15:0] r_pi, n_pi;         // payload index
    logic [5:0]  r_ei, n_ei;         // emitted text count
    logic        r_pend, n_pend;     // read in flight
    t_out        r_out, n_out;
    logic        r_ovalid, n_ovalid;
    logic [3:0]  r_after, n_after;   // state after output taken
    logic [AW-1:0] r_addr, n_addr;
    logic [AW:0]  base;

    assign base = i_ack ? (AW+1)'(4) : (AW+1)'(3);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_rd_addr   = r_addr;

    // next-state and datapath commands
    always_comb begin
        logic [16:0] need;
        n_state = r_state; n_idle = r_idle; n_req = r_req; n_await = r_await;
        n_ok = r_ok; n_hidx = r_hidx; n_pi = r_pi; n_ei = r_ei; n_pend = r_pend;
        n_out = r_out; n_ovalid = r_ovalid; n_after = r_after;
        n_addr = r_addr;
        o_cmd = '0;
        need = '0;
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
            n_state = r_after;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && !r_ovalid) begin
                    n_out = '0;
                    unique case (i_in.data.operation)
                        OP_BYTE: begin
                            n_idle = '0;
                            if (!(i_count == '0 && i_in.data.rx_byte != CH_HASH)) begin
                                if (i_count >= CW'(FRAME_DEPTH)) begin
                                    o_cmd.clr_count = 1'b1;
                                    n_out.status = ST_OVERFLOW;
                                    n_out.request_ok = r_ok;
                                    n_out.last = 1'b1;
                                    n_ovalid = 1'b1;
                                    n_state = S_OUT;
                                    n_after = S_IDLE;
                                end else begin
                                    o_cmd.store_byte = 1'b1;
                                    n_state = S_CHECK;
                                end
                            end
                        end
                        OP_TICK: begin
                            n_idle = (r_idle != 16'hFFFF) ? r_idle + 16'd1 : r_idle;
                            n_req  = (r_req != 16'hFFFF) ? r_req + 16'd1 : r_req;
                            if (i_count != '0) begin
                                if (n_idle >= i_timeout) begin
                                    o_cmd.clr_count = 1'b1;
                                    n_await = 1'b0; n_ok = 1'b0;
                                    n_out.status = ST_FTIMEOUT;
                                    n_out.last = 1'b1;
                                    n_ovalid = 1'b1;
                                    n_state = S_OUT; n_after = S_IDLE;
                                end
                            end else if (r_await && n_req >= i_timeout) begin
                                n_await = 1'b0; n_ok = 1'b0;
                                n_out.status = ST_RTIMEOUT;
                                n_out.last = 1'b1;
                                n_ovalid = 1'b1;
                                n_state = S_OUT; n_after = S_IDLE;
                            end
                        end
                        OP_REQ: begin
                            n_req = '0; n_await = 1'b1; n_ok = 1'b0;
                            o_cmd.clr_count = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // end marker flags are updated by the datapath on store
                if (i_end_seen) begin
                    n_await = 1'b0;
                    if (i_count < CW'(8)) begin
                        n_out = '0;
                        n_out.status = ST_SHORT;
                        n_out.request_ok = r_ok;
                        n_out.last = 1'b1;
                        o_cmd.clr_count = 1'b1;
                        n_ovalid = 1'b1;
                        n_state = S_OUT; n_after = S_IDLE;
                    end else begin
                        n_hidx = 3'd1;
                        n_addr = AW'(1);
                        n_pend = 1'b0;
                        n_state = S_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                // issue then latch header bytes 1..3 and length
                o_cmd.rd_en = 1'b1;
                n_state = S_HDR;
            end
            S_HDR: begin
                o_cmd.ld_byte = 1'b1;
                unique case (r_hidx)
                    3'd1: o_cmd.ld_sel = LD_OP;
                    3'd2: o_cmd.ld_sel = LD_CMD;
                    3'd3: o_cmd.ld_sel = LD_ACK;
                    3'd4: o_cmd.ld_sel = LD_LENL;
                    default: o_cmd.ld_sel = LD_LENH;
                endcase
                n_hidx = r_hidx + 3'd1;
                if (r_hidx == 3'd3) begin
                    // base is known next cycle; check invalid there
                    n_state = S_SUM;
                end else if (r_hidx == 3'd5) begin
                    n_state = S_SUM;
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_state = S_RD;
                end
            end
            S_SUM: begin
                n_out = '0;
                n_out.op_code = i_op;
                n_out.command = i_cmd;
                n_out.has_ack = i_ack;
                n_out.request_ok = r_ok;
                n_out.last = 1'b1;
                if (r_hidx == 3'd4) begin
                    if (CW'(base) + CW'(6) > i_count) begin
                        n_out.status = ST_INVALID;
                        o_cmd.clr_count = 1'b1;
                        n_ovalid = 1'b1;
                        n_state = S_OUT; n_after = S_IDLE;
                    end else begin
                        n_addr = AW'(base);
                        n_state = S_RD;
                    end
                end else begin
                    n_out.payload_length = i_len;
                    need = 17'(base) + {1'b0, i_len} + 17'd5;
                    if (need >= 17'(i_count)) begin
                        n_out.status = ST_LEN;
                        o_cmd.clr_count = 1'b1;
                        n_ovalid = 1'b1;
                        n_state = S_OUT; n_after = S_IDLE;
                    end else begin
                        o_cmd.text_start = 1'b1;
                        n_pi = '0;
                        n_addr = AW'(base + (AW+1)'(2));
                        n_pend = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // walk payload to count printable characters
                if (r_pend) begin
                    o_cmd.text_step = 1'b1;
                end
                if (r_pend && i_text_is_zero) begin
                    n_pend = 1'b0;
                    n_state = S_EMIT;
                end else if (r_pi < i_len) begin
                    o_cmd.rd_en = 1'b1;
                    n_pend = 1'b1;
                    n_pi = r_pi + 16'd1;
                    n_addr = r_addr + AW'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_ok = 1'b1;
                n_out.status = ST_OK;
                n_out.text_length = i_tl;
                n_out.request_ok = 1'b1;
                if (i_tl != '0 && i_cmd == CMD_FW) n_out.identity = ID_FW;
                else if (i_tl != '0 && i_cmd == CMD_MDL) n_out.identity = ID_MDL;
                else n_out.identity = ID_NONE;
                n_out.last = (n_out.identity == ID_NONE);
                o_cmd.clr_count = 1'b1;
                n_ovalid = 1'b1;
                n_ei = '0;
                n_pi = '0;
                n_addr = AW'(base + (AW+1)'(2));
                n_state = S_OUT;
                n_after = n_out.last ? S_IDLE : S_EMRD;
            end
            S_EMRD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_EMCH;
            end
            S_EMCH: begin
                if (i_text_ok) begin
                    n_out.kind = 1'b1;
                    n_out.text_char = i_text_char;
                    n_out.last = (r_ei + 6'd1 == r_out.text_length);
                    n_ei = r_ei + 6'd1;
                    n_ovalid = 1'b1;
                    n_addr = r_addr + AW'(1);
                    n_state = S_OUT;
                    n_after = n_out.last ? S_IDLE : S_EMRD;
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_state = S_EMRD;
                end
            end
            S_OUT: begin
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_idle <= '0; r_req <= '0; r_await <= 1'b0;
            r_ok <= 1'b0; r_ovalid <= 1'b0; r_after <= S_IDLE; r_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_idle <= n_idle; r_req <= n_req; r_await <= n_await;
            r_ok <= n_ok; r_ovalid <= n_ovalid; r_after <= n_after; r_pend <= n_pend;
        end
        r_hidx <= n_hidx; r_pi <= n_pi; r_ei <= n_ei; r_out <= n_out; r_addr <= n_addr;
    end
endmodule

>>> src/crd_dp.sv
// Datapath: frame store, fill count, end marker window and header/text registers.
module crd_dp #(
    parameter int FRAME_DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  crd_pkg::t_cmd           i_cmd,
    input  logic [7:0]              i_byte,
    input  logic [$clog2(FRAME_DEPTH)-1:0] i_rd_addr,
    output logic [$clog2(FRAME_DEPTH+1)-1:0] o_count,
    output logic                    o_end_seen,
    output logic [7:0]              o_op,
    output logic [7:0]              o_cmd,
    output logic                    o_ack,
    output logic [15:0]             o_len,
    output logic [5:0]              o_tl,
    output logic                    o_text_ok,
    output logic [7:0]              o_text_char,
    output logic                    o_text_is_zero
);
    import crd_pkg::*;

    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    logic [CW-1:0] r_count;
    logic [7:0]    r_w0, r_w1, r_w2;   // last three stored bytes
    logic [7:0]    r_op, r_cmdb, r_lenl, r_lenh;
    logic          r_ack;
    logic [5:0]    r_tl;
    logic          r_done;
    logic [7:0]    rdata;
    logic          printable;

    crd_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store_byte),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_byte),
        .i_raddr(i_rd_addr),
        .o_rdata(rdata)
    );

    assign printable = (rdata >= CH_LOW) && (rdata <= CH_HIGH);

    // count, marker window, header and text count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr_count) begin
            r_count <= '0;
        end else if (i_cmd.store_byte) begin
            r_count <= r_count + CW'(1);
        end
        if (i_cmd.store_byte) begin
            r_w2 <= r_w1; r_w1 <= r_w0; r_w0 <= i_byte;
        end
        if (i_cmd.ld_byte) begin
            unique case (i_cmd.ld_sel)
                LD_OP:   r_op <= rdata;
                LD_CMD:  r_cmdb <= rdata;
                LD_ACK:  r_ack <= (rdata == CH_Y);
                LD_LENL: r_lenl <= rdata;
                default: r_lenh <= rdata;
            endcase
        end
        if (i_cmd.text_start) begin
            r_tl <= '0; r_done <= 1'b0;
        end else if (i_cmd.text_step && !r_done) begin
            if (rdata == 8'd0) r_done <= 1'b1;
            else if (printable && r_tl < MAX_TEXT) r_tl <= r_tl + 6'd1;
        end
    end

    assign o_count = r_count;
    assign o_end_seen = (r_count >= CW'(3)) && r_w2 == CH_E && r_w1 == CH_N && r_w0 == CH_D;
    assign o_op = r_op;
    assign o_cmd = r_cmdb;
    assign o_ack = r_ack;
    assign o_len = {r_lenh, r_lenl};
    assign o_tl = r_tl;
    assign o_text_ok = printable;
    assign o_text_char = rdata;
    assign o_text_is_zero = (rdata == 8'd0);
endmodule

>>> src/camera_response_deframer.sv
// Top level of the camera response deframer.
// Takes received bytes, ticks and request marks one beat at a time and emits a
// summary beat for each completed frame, timeout or overflow, followed by the
// printable payload text of identity frames. No new beat is taken while a
// byte or frame is in progress or a result beat waits. An ending frame goes
// through intake and end check, the header walk, a payload scan up to the first
// zero or the payload length, the summary, then text characters read one by one
// through the single registered read port of the frame store, skipping
// non-printable bytes; a stalled receiver adds its wait to every result beat.
// The store needs no clearing after reset.
module camera_response_deframer #(
    parameter int FRAME_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    crd_if.sink         i_in,
    crd_if.source       o_out
);
    import crd_pkg::*;

    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    logic [15:0]   r_timeout;
    t_cmd          cmd;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count;
    logic          end_seen, ack, text_ok, text_zero;
    logic [7:0]    op, cmdb, tchar;
    logic [15:0]   len;
    logic [5:0]    tl;

    // hold timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    crd_ctrl #(.FRAME_DEPTH(FRAME_DEPTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .o_out(o_out),
        .i_timeout(r_timeout), .i_count(count), .i_end_seen(end_seen),
        .i_op(op), .i_cmd(cmdb), .i_ack(ack), .i_len(len), .i_tl(tl),
        .i_text_ok(text_ok), .i_text_char(tchar), .i_text_is_zero(text_zero),
        .o_cmd(cmd), .o_rd_addr(rd_addr)
    );

    crd_dp #(.FRAME_DEPTH(FRAME_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(i_in.data.rx_byte),
        .i_rd_addr(rd_addr), .o_count(count), .o_end_seen(end_seen),
        .o_op(op), .o_cmd(cmdb), .o_ack(ack), .o_len(len), .o_tl(tl),
        .o_text_ok(text_ok), .o_text_char(tchar), .o_text_is_zero(text_zero)
    );
endmodule
